/* sv/ckfc_pkg.sv */
// ckfc_pkg: shared types, codes and color distance helpers for the chroma key core
// no dependencies
`timescale 1ns / 1ps

package ckfc_pkg;

   // request payload
   typedef struct packed {
      logic       opcode;
      logic [7:0] in_red;
      logic [7:0] in_green;
      logic [7:0] in_blue;
      logic [7:0] in_alpha;
   } req_type;

   // response payload
   typedef struct packed {
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic [7:0] out_alpha;
      logic [1:0] removal_cause;
      logic       frame_last;
   } rsp_type;

   // configuration registers
   typedef struct packed {
      logic [7:0]  key_red;
      logic [7:0]  key_green;
      logic [7:0]  key_blue;
      logic [17:0] tight_limit_sq;
      logic [17:0] loose_limit_sq;
      logic [11:0] image_width;
      logic [11:0] image_height;
   } cfg_type;

   // one pending pixel in the line store
   typedef struct packed {
      logic       tight;
      logic [7:0] alpha;
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } pix_word_type;

   // what the front hands to the back along with the line store read
   typedef struct packed {
      logic valid;
      logic fringe_ok;
      logic last;
   } emit_token_type;

   typedef enum logic [1:0] {
      CAUSE_KEPT   = 2'd0,
      CAUSE_TIGHT  = 2'd1,
      CAUSE_FRINGE = 2'd2
   } cause_type;

   typedef enum logic [2:0] {
      REG_KEY_RED      = 3'd0,
      REG_KEY_GREEN    = 3'd1,
      REG_KEY_BLUE     = 3'd2,
      REG_TIGHT_LIMIT  = 3'd3,
      REG_LOOSE_LIMIT  = 3'd4,
      REG_IMAGE_WIDTH  = 3'd5,
      REG_IMAGE_HEIGHT = 3'd6
   } csr_index_type;

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   localparam int OUT_QUEUE_DEPTH = 8;

   localparam logic [17:0] TIGHT_RESET  = 18'd900;
   localparam logic [17:0] LOOSE_RESET  = 18'd14400;
   localparam logic [11:0] WIDTH_RESET  = 12'd640;
   localparam logic [11:0] HEIGHT_RESET = 12'd480;

   // squared difference of two color components
   function automatic logic [15:0] sq_diff(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] d;
      d = (a >= b) ? (a - b) : (b - a);
      return 16'(d) * 16'(d);
   endfunction

   // summed squares against a limit
   function automatic logic dist_le(input logic [15:0] sr, input logic [15:0] sg,
                                    input logic [15:0] sb, input logic [17:0] lim);
      logic [17:0] s;
      s = 18'(sr) + 18'(sg) + 18'(sb);
      return s <= lim;
   endfunction

endpackage

/* sv/chroma_key_with_fringe_cleanup_core.sv */
// chroma_key_with_fringe_cleanup_core: top level, register file and credit count
// depends on ckfc_pkg, ckfc_front, ckfc_back, ckfc_ram
`timescale 1ns / 1ps

//  port group | direction | handshake           | payload
//  req_       | in        | req_valid/req_ready | req_type: opcode, rgba
//  rsp_       | out       | rsp_valid/rsp_ready | rsp_type: rgba, cause, frame_last
//  csr_       | in        | psel/penable/pready | 32-bit registers at 4*index
//
// one request per clock sustained while credits last; a pixel's response leaves one row plus
// one pixel later in the stream, after passing through intake, line store and queue
// the line store has one write and one read port, which sets the one per clock rate
// reset clears counters, pointers, valids and config; line stores start undefined, no sweep
// requests stall only when the response queue credits run out

module chroma_key_with_fringe_cleanup_core
   import ckfc_pkg::*;
#(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 2048
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int CC = $clog2(OUT_QUEUE_DEPTH + 1);

   cfg_type        cfg_ff;
   csr_index_type  csr_idx;
   logic           csr_wr;
   emit_token_type emit;
   pix_word_type   pix_rd;
   logic [CC-1:0]  credit_ff;
   logic           credit_full, rsp_pop;

   // register file
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_index_type'(csr_paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.key_red        <= 8'd0;
         cfg_ff.key_green      <= 8'd0;
         cfg_ff.key_blue       <= 8'd0;
         cfg_ff.tight_limit_sq <= TIGHT_RESET;
         cfg_ff.loose_limit_sq <= LOOSE_RESET;
         cfg_ff.image_width    <= WIDTH_RESET;
         cfg_ff.image_height   <= HEIGHT_RESET;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_KEY_RED:      cfg_ff.key_red        <= csr_pwdata[7:0];
            REG_KEY_GREEN:    cfg_ff.key_green      <= csr_pwdata[7:0];
            REG_KEY_BLUE:     cfg_ff.key_blue       <= csr_pwdata[7:0];
            REG_TIGHT_LIMIT:  cfg_ff.tight_limit_sq <= csr_pwdata[17:0];
            REG_LOOSE_LIMIT:  cfg_ff.loose_limit_sq <= csr_pwdata[17:0];
            REG_IMAGE_WIDTH:  cfg_ff.image_width    <= csr_pwdata[11:0];
            REG_IMAGE_HEIGHT: cfg_ff.image_height   <= csr_pwdata[11:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_KEY_RED:      csr_prdata = {24'd0, cfg_ff.key_red};
         REG_KEY_GREEN:    csr_prdata = {24'd0, cfg_ff.key_green};
         REG_KEY_BLUE:     csr_prdata = {24'd0, cfg_ff.key_blue};
         REG_TIGHT_LIMIT:  csr_prdata = {14'd0, cfg_ff.tight_limit_sq};
         REG_LOOSE_LIMIT:  csr_prdata = {14'd0, cfg_ff.loose_limit_sq};
         REG_IMAGE_WIDTH:  csr_prdata = {20'd0, cfg_ff.image_width};
         REG_IMAGE_HEIGHT: csr_prdata = {20'd0, cfg_ff.image_height};
         default:          csr_prdata = 32'd0;
      endcase
   end

   // responses in flight between commit and delivery
   assign rsp_pop     = rsp_valid && rsp_ready;
   assign credit_full = (credit_ff == CC'(OUT_QUEUE_DEPTH));

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff <= '0;
      end else begin
         credit_ff <= credit_ff + CC'(emit.valid) - CC'(rsp_pop);
      end
   end

   ckfc_front #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_HEIGHT(MAX_HEIGHT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .cfg        (cfg_ff),
      .credit_full(credit_full),
      .emit       (emit),
      .pix_rd     (pix_rd)
   );

   ckfc_back u_back (
      .clock    (clock),
      .reset    (reset),
      .emit     (emit),
      .pix_rd   (pix_rd),
      .cfg      (cfg_ff),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   // credit count never passes the queue depth
   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      32'(credit_ff) <= OUT_QUEUE_DEPTH)
      else $error("credit count overflow");

   // a waiting response is always covered by a credit
   a_rsp_credit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> credit_ff != '0)
      else $error("response without credit");

   // intake only holds off when the queue is fully booked
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> credit_full)
      else $error("stall without full credits");

   // no commit is issued while credits are exhausted
   a_no_overbook: assert property (@(posedge clock) disable iff (reset)
      (credit_full && !rsp_pop) |-> !emit.valid)
      else $error("commit beyond credits");

endmodule

/* sv/ckfc_ram.sv */
// ckfc_ram: generic single write, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module ckfc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/ckfc_front.sv */
// ckfc_front: request intake, tight match, line store and 3x3 flag window
// depends on ckfc_pkg and ckfc_ram
`timescale 1ns / 1ps

module ckfc_front
   import ckfc_pkg::*;
#(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 2048
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  req_type        req_data,
   input  cfg_type        cfg,
   input  logic           credit_full,
   output emit_token_type emit,
   output pix_word_type   pix_rd
);

   localparam int PD = MAX_WIDTH + 2;
   localparam int PA = $clog2(PD);
   localparam int FA = $clog2(MAX_WIDTH);
   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int RW = $clog2(MAX_HEIGHT + 1);
   localparam int NW = $clog2(MAX_WIDTH + 3);

   // intake pipeline
   logic              s1_v_ff, s2_v_ff;
   req_type           s1_req_ff, s2_req_ff;
   logic [2:0][15:0]  s1_sq_ff;
   logic              s2_tight_ff;

   // frame counters and pointers
   logic [CW-1:0] icol_ff, ocol_ff;
   logic [RW-1:0] irow_ff, orow_ff;
   logic [NW-1:0] pend_ff;
   logic [PA-1:0] pwp_ff, prp_ff;
   logic [FA-1:0] fwp_ff;
   logic          b1_ff, b2_ff, m1_ff, m2_ff, t1_ff, t2_ff;

   logic          advance, fire;
   logic [WW-1:0] w_eff;
   logic [RW-1:0] h_eff;
   logic          is_pixel, frame_done, push, pix_emit, drain_act, drain_emit;
   logic          emit_any, last, clear, flag_now, found, interior;
   logic [NW-1:0] pend_push;
   logic [1:0]    flag_rd;
   logic [FA-1:0] flag_raddr;
   logic [31:0]   flag_sum;
   pix_word_type  pix_wr;

   assign advance   = !(s2_v_ff && credit_full);
   assign req_ready = advance;
   assign fire      = s2_v_ff && advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else if (advance) begin
         s1_v_ff <= req_valid;
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_req_ff   <= req_data;
         s1_sq_ff[0] <= sq_diff(req_data.in_red, cfg.key_red);
         s1_sq_ff[1] <= sq_diff(req_data.in_green, cfg.key_green);
         s1_sq_ff[2] <= sq_diff(req_data.in_blue, cfg.key_blue);
         s2_req_ff   <= s1_req_ff;
         s2_tight_ff <= dist_le(s1_sq_ff[0], s1_sq_ff[1], s1_sq_ff[2], cfg.tight_limit_sq);
      end
   end

   // frame size clamped to the supported range
   always_comb begin
      if (cfg.image_width == 12'd0) begin
         w_eff = WW'(1);
      end else if (32'(cfg.image_width) > MAX_WIDTH) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(cfg.image_width);
      end
      if (cfg.image_height == 12'd0) begin
         h_eff = RW'(1);
      end else if (32'(cfg.image_height) > MAX_HEIGHT) begin
         h_eff = RW'(MAX_HEIGHT);
      end else begin
         h_eff = RW'(cfg.image_height);
      end
   end

   // commit decisions
   always_comb begin
      is_pixel   = (s2_req_ff.opcode == OP_PIXEL);
      frame_done = (irow_ff >= h_eff);
      push       = fire && is_pixel && !frame_done;
      pend_push  = pend_ff + NW'(push);
      pix_emit   = push && (32'(pend_push) > 32'(w_eff) + 32'd1);
      drain_act  = fire && !is_pixel && frame_done;
      drain_emit = drain_act && (pend_ff != '0);
      emit_any   = pix_emit || drain_emit;
      last       = drain_emit && (pend_ff == NW'(1));
      clear      = (drain_act && (pend_ff == '0)) || last;
   end

   // 3x3 flag window around the emitted pixel, center excluded
   assign flag_now = s2_tight_ff || (s2_req_ff.in_alpha == 8'd0);
   assign found    = flag_now | b1_ff | b2_ff | flag_rd[0] | m2_ff |
                     flag_rd[1] | t1_ff | t2_ff;
   assign interior = (orow_ff != '0) && (32'(orow_ff) + 32'd2 <= 32'(h_eff)) &&
                     (ocol_ff != '0) && (32'(ocol_ff) + 32'd2 <= 32'(w_eff));

   assign emit.valid     = emit_any;
   assign emit.fringe_ok = pix_emit && interior && found;
   assign emit.last      = last;

   always_ff @(posedge clock) begin
      if (reset) begin
         icol_ff <= '0;
         irow_ff <= '0;
         ocol_ff <= '0;
         orow_ff <= '0;
         pend_ff <= '0;
         pwp_ff  <= '0;
         prp_ff  <= '0;
         fwp_ff  <= '0;
      end else begin
         if (clear) begin
            icol_ff <= '0;
            irow_ff <= '0;
            ocol_ff <= '0;
            orow_ff <= '0;
            pend_ff <= '0;
         end else begin
            if (push) begin
               if (32'(icol_ff) + 32'd1 >= 32'(w_eff)) begin
                  icol_ff <= '0;
                  irow_ff <= irow_ff + RW'(1);
               end else begin
                  icol_ff <= icol_ff + CW'(1);
               end
            end
            if (emit_any) begin
               if (32'(ocol_ff) + 32'd1 >= 32'(w_eff)) begin
                  ocol_ff <= '0;
                  orow_ff <= orow_ff + RW'(1);
               end else begin
                  ocol_ff <= ocol_ff + CW'(1);
               end
            end
            pend_ff <= pend_push - NW'(emit_any);
         end
         if (push) begin
            pwp_ff <= (pwp_ff == PA'(PD - 1)) ? '0 : pwp_ff + PA'(1);
            fwp_ff <= (32'(fwp_ff) == MAX_WIDTH - 1) ? '0 : fwp_ff + FA'(1);
         end
         if (emit_any) begin
            prp_ff <= (prp_ff == PA'(PD - 1)) ? '0 : prp_ff + PA'(1);
         end
      end
   end

   // window shift registers move on every stored pixel
   // m1 holds the center pixel itself, only passed on to m2
   always_ff @(posedge clock) begin
      if (push) begin
         b1_ff <= flag_now;
         b2_ff <= b1_ff;
         m1_ff <= flag_rd[0];
         m2_ff <= m1_ff;
         t1_ff <= flag_rd[1];
         t2_ff <= t1_ff;
      end
   end

   // flag line: entry read now is one row back at the next stored pixel
   always_comb begin
      flag_sum = 32'(fwp_ff) + MAX_WIDTH + 1 - 32'(w_eff);
      if (flag_sum >= MAX_WIDTH) begin
         flag_sum = flag_sum - MAX_WIDTH;
      end
      flag_raddr = FA'(flag_sum);
   end

   ckfc_ram #(
      .WIDTH(2),
      .DEPTH(MAX_WIDTH)
   ) u_flag_ram (
      .clock  (clock),
      .wr_en  (push),
      .wr_addr(fwp_ff),
      .wr_data({flag_rd[0], flag_now}),
      .rd_en  (push),
      .rd_addr(flag_raddr),
      .rd_data(flag_rd)
   );

   always_comb begin
      pix_wr.tight = s2_tight_ff;
      pix_wr.alpha = s2_req_ff.in_alpha;
      pix_wr.blue  = s2_req_ff.in_blue;
      pix_wr.green = s2_req_ff.in_green;
      pix_wr.red   = s2_req_ff.in_red;
   end

   ckfc_ram #(
      .WIDTH($bits(pix_word_type)),
      .DEPTH(PD)
   ) u_pix_ram (
      .clock  (clock),
      .wr_en  (push),
      .wr_addr(pwp_ff),
      .wr_data(pix_wr),
      .rd_en  (emit_any),
      .rd_addr(prp_ff),
      .rd_data(pix_rd)
   );

endmodule

/* sv/ckfc_back.sv */
// ckfc_back: loose match on emitted pixels, removal cause and response queue
// depends on ckfc_pkg
`timescale 1ns / 1ps

module ckfc_back
   import ckfc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  emit_token_type emit,
   input  pix_word_type   pix_rd,
   input  cfg_type        cfg,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output rsp_type        rsp_data
);

   localparam int QA = $clog2(OUT_QUEUE_DEPTH);

   emit_token_type   p1_tok_ff, p2_tok_ff;
   pix_word_type     p2_word_ff;
   logic [2:0][15:0] p2_sq_ff;

   rsp_type         q_ff [OUT_QUEUE_DEPTH];
   logic [QA-1:0]   head_ff, tail_ff;
   logic [QA:0]     cnt_ff;
   rsp_type         res;
   logic            loose, pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_tok_ff <= '0;
         p2_tok_ff <= '0;
      end else begin
         p1_tok_ff <= emit;
         p2_tok_ff <= p1_tok_ff;
      end
   end

   always_ff @(posedge clock) begin
      p2_word_ff  <= pix_rd;
      p2_sq_ff[0] <= sq_diff(pix_rd.red, cfg.key_red);
      p2_sq_ff[1] <= sq_diff(pix_rd.green, cfg.key_green);
      p2_sq_ff[2] <= sq_diff(pix_rd.blue, cfg.key_blue);
   end

   always_comb begin
      loose            = dist_le(p2_sq_ff[0], p2_sq_ff[1], p2_sq_ff[2], cfg.loose_limit_sq);
      res.out_red      = p2_word_ff.red;
      res.out_green    = p2_word_ff.green;
      res.out_blue     = p2_word_ff.blue;
      res.out_alpha    = p2_word_ff.alpha;
      res.removal_cause = CAUSE_KEPT;
      res.frame_last   = p2_tok_ff.last;
      if (p2_word_ff.tight) begin
         res.out_alpha     = 8'd0;
         res.removal_cause = CAUSE_TIGHT;
      end else if ((p2_word_ff.alpha != 8'd0) && p2_tok_ff.fringe_ok && loose) begin
         res.out_alpha     = 8'd0;
         res.removal_cause = CAUSE_FRINGE;
      end
   end

   // room is guaranteed by the credit count at the top
   assign pop       = rsp_valid && rsp_ready;
   assign rsp_valid = (cnt_ff != '0);
   assign rsp_data  = q_ff[head_ff];

   always_ff @(posedge clock) begin
      if (p2_tok_ff.valid) begin
         q_ff[tail_ff] <= res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         if (p2_tok_ff.valid) begin
            tail_ff <= tail_ff + QA'(1);
         end
         if (pop) begin
            head_ff <= head_ff + QA'(1);
         end
         cnt_ff <= cnt_ff + (QA + 1)'(p2_tok_ff.valid) - (QA + 1)'(pop);
      end
   end

endmodule

/* sim/tb_chroma_key_with_fringe_cleanup_core.sv */
// tb_chroma_key_with_fringe_cleanup_core: self-checking bench for the chroma key core,
// with a directed table, random frames and a predictor of both removal passes
// depends on ckfc_pkg and chroma_key_with_fringe_cleanup_core
`timescale 1ns / 1ps

module tb_chroma_key_with_fringe_cleanup_core;
   import ckfc_pkg::*;

   localparam int MAX_W      = 2048;
   localparam int MAX_H      = 2048;
   localparam int PIX_DEPTH  = MAX_W + 2;
   localparam int FLAG_DEPTH = 2 * MAX_W + 4;
   // margin for the pipeline to empty; leave room for queued requests too
   localparam int SETTLE     = 40;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [4:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   chroma_key_with_fringe_cleanup_core #(.MAX_WIDTH(MAX_W), .MAX_HEIGHT(MAX_H)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------------
   // keyer predictor: register copies, line store and clear-flag history
   // ---------------------------------------------------------------------------
   int unsigned key_r, key_g, key_b, tight_lim, loose_lim, width_reg, height_reg;
   bit [32:0]   line_store [PIX_DEPTH];
   bit          clear_hist [FLAG_DEPTH];
   int unsigned in_col, in_row, out_col, out_row, pending, store_wp, hist_wp;

   rsp_type     expected_pixels[$];
   int          mismatches = 0;

   function automatic int unsigned key_dist(int r, int g, int b);
      return (r - key_r) * (r - key_r) + (g - key_g) * (g - key_g) +
             (b - key_b) * (b - key_b);
   endfunction

   function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
      return (v < 1) ? 1 : ((v > hi) ? hi : v);
   endfunction

   function automatic void reset_counters();
      in_col = 0; in_row = 0; out_col = 0; out_row = 0; pending = 0;
   endfunction

   function automatic void apply_csr(csr_index_type idx, int unsigned v);
      case (idx)
         REG_KEY_RED:      key_r = v & 8'hff;
         REG_KEY_GREEN:    key_g = v & 8'hff;
         REG_KEY_BLUE:     key_b = v & 8'hff;
         REG_TIGHT_LIMIT:  tight_lim = v & 18'h3ffff;
         REG_LOOSE_LIMIT:  loose_lim = v & 18'h3ffff;
         REG_IMAGE_WIDTH:  width_reg = v & 12'hfff;
         REG_IMAGE_HEIGHT: height_reg = v & 12'hfff;
         default: ;
      endcase
   endfunction

   // pops the oldest pending pixel and decides its cause
   function automatic rsp_type pop_pixel(bit fringe_pass, int unsigned w, int unsigned h);
      bit [32:0]   word;
      rsp_type     o;
      bit          hit;
      int          nb;
      word = line_store[(store_wp + PIX_DEPTH - (pending % PIX_DEPTH)) % PIX_DEPTH];
      o.out_red = word[7:0];
      o.out_green = word[15:8];
      o.out_blue = word[23:16];
      o.out_alpha = word[31:24];
      o.removal_cause = CAUSE_KEPT;
      o.frame_last = 1'b0;
      if (word[32]) begin
         o.removal_cause = CAUSE_TIGHT;
         o.out_alpha = 8'd0;
      end else if (word[31:24] != 0 && fringe_pass && out_row >= 1 && out_row + 2 <= h &&
                   out_col >= 1 && out_col + 2 <= w &&
                   key_dist(word[7:0], word[15:8], word[23:16]) <= loose_lim) begin
         hit = 1'b0;
         for (int dy = -1; dy <= 1; dy++) begin
            for (int dx = -1; dx <= 1; dx++) begin
               nb = int'(pending) - dy * int'(w) - dx;
               if ((dy != 0 || dx != 0) && nb >= 1 && nb < FLAG_DEPTH)
                  if (clear_hist[(hist_wp + FLAG_DEPTH - nb) % FLAG_DEPTH]) hit = 1'b1;
            end
         end
         if (hit) begin
            o.removal_cause = CAUSE_FRINGE;
            o.out_alpha = 8'd0;
         end
      end
      if (pending > 0) pending--;
      if (out_col + 1 >= w) begin
         out_col = 0;
         out_row++;
      end else out_col++;
      return o;
   endfunction

   // returns 1 when the accepted request produces a pixel out
   function automatic bit predict_pixel(req_type q, output rsp_type o);
      int unsigned w, h;
      bit          tight;
      w = clamp_dim(width_reg, MAX_W);
      h = clamp_dim(height_reg, MAX_H);
      o = '0;
      if (q.opcode == OP_PIXEL) begin
         if (in_row >= h) return 1'b0;
         tight = key_dist(q.in_red, q.in_green, q.in_blue) <= tight_lim;
         line_store[store_wp] = {tight, q.in_alpha, q.in_blue, q.in_green, q.in_red};
         store_wp = (store_wp + 1) % PIX_DEPTH;
         clear_hist[hist_wp] = tight || q.in_alpha == 0;
         hist_wp = (hist_wp + 1) % FLAG_DEPTH;
         pending++;
         if (in_col + 1 >= w) begin
            in_col = 0;
            in_row++;
         end else in_col++;
         if (pending > w + 1) begin
            o = pop_pixel(1'b1, w, h);
            return 1'b1;
         end
         return 1'b0;
      end
      if (in_row < h) return 1'b0;
      if (pending == 0) begin
         reset_counters();
         return 1'b0;
      end
      o = pop_pixel(1'b0, w, h);
      if (pending == 0) begin
         o.frame_last = 1'b1;
         reset_counters();
      end
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------------------
   // response side: stall pattern and field compare
   // ---------------------------------------------------------------------------
   int unsigned stall_mode = 0;
   int unsigned stall_tick = 0;

   always @(negedge clock) begin
      stall_tick <= stall_tick + 1;
      if (stall_tick % 150 == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_ready <= 1'b1;                          // no back pressure
         1: rsp_ready <= ($urandom_range(0, 9) < 7);    // light random stalls
         2: rsp_ready <= (stall_tick % 5 == 0);         // one in five
         default: rsp_ready <= ($urandom_range(0, 9) < 2); // heavy stalls
      endcase
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_pixels.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected pixel out: %p", rsp_data);
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_data.out_red !== want.out_red || rsp_data.out_green !== want.out_green ||
                rsp_data.out_blue !== want.out_blue || rsp_data.out_alpha !== want.out_alpha ||
                rsp_data.removal_cause !== want.removal_cause ||
                rsp_data.frame_last !== want.frame_last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("pixel out differs: expected %p, got %p", want, rsp_data);
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // request side: bursty sender and register writes
   // ---------------------------------------------------------------------------
   int unsigned burst_left;
   int unsigned items_sent;

   // one request, waited out until accepted; valid stays up inside a burst
   task automatic send_request(req_type q, bit typed_known = 1'b0,
                               rsp_type typed = '0);
      rsp_type o;
      @(negedge clock);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         if ($urandom_range(0, 2) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data <= q;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      if (predict_pixel(q, o)) expected_pixels.push_back(typed_known ? typed : o);
   endtask

   // drain outstanding pixels before touching a register
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, int unsigned v);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= v;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      apply_csr(idx, v);
   endtask

   // ---------------------------------------------------------------------------
   // directed table: three single-pixel frames, then a 3x3 fringe case
   // ---------------------------------------------------------------------------
   typedef struct {
      bit            is_csr;
      csr_index_type idx;
      int unsigned   value;
      req_type       q;
      bit            known;
      rsp_type       typed;
   } step_row_type;

   step_row_type steps[$];

   function automatic void add_csr(csr_index_type idx, int unsigned v);
      steps.push_back('{1'b1, idx, v, '0, 1'b0, '0});
   endfunction

   function automatic void add_req(logic op, int r, int g, int b, int a,
                                   bit known = 1'b0, rsp_type typed = '0);
      steps.push_back('{1'b0, REG_KEY_RED, 0, '{op, 8'(r), 8'(g), 8'(b), 8'(a)},
                        known, typed});
   endfunction

   function automatic void build_directed();
      add_csr(REG_KEY_RED, 0);
      add_csr(REG_KEY_GREEN, 0);
      add_csr(REG_KEY_BLUE, 0);
      add_csr(REG_TIGHT_LIMIT, 0);
      add_csr(REG_LOOSE_LIMIT, 195075);
      add_csr(REG_IMAGE_WIDTH, 1);
      add_csr(REG_IMAGE_HEIGHT, 1);
      // single-pixel frames: exact key, far white, transparent input
      add_req(OP_PIXEL, 0, 0, 0, 255);
      add_req(OP_DRAIN, 0, 0, 0, 0, 1'b1, '{8'd0, 8'd0, 8'd0, 8'd0, CAUSE_TIGHT, 1'b1});
      add_req(OP_PIXEL, 255, 255, 255, 255);
      add_req(OP_DRAIN, 255, 255, 255, 255, 1'b1,
              '{8'd255, 8'd255, 8'd255, 8'd255, CAUSE_KEPT, 1'b1});
      add_req(OP_PIXEL, 128, 0, 0, 0);
      add_req(OP_DRAIN, 0, 0, 0, 0, 1'b1, '{8'd128, 8'd0, 8'd0, 8'd0, CAUSE_KEPT, 1'b1});
      // drain on an empty, fresh frame is ignored
      add_req(OP_DRAIN, 1, 2, 3, 4);
      add_csr(REG_IMAGE_WIDTH, 3);
      add_csr(REG_IMAGE_HEIGHT, 3);
      // 3x3: keyed corner makes the grey center a fringe pixel
      add_req(OP_PIXEL, 0, 0, 0, 255);
      add_req(OP_PIXEL, 255, 255, 255, 255);
      add_req(OP_DRAIN, 9, 9, 9, 9);                // drain mid-frame is ignored
      add_req(OP_PIXEL, 255, 255, 255, 255);
      add_req(OP_PIXEL, 255, 0, 255, 17);
      add_req(OP_PIXEL, 100, 100, 100, 255);
      add_req(OP_PIXEL, 255, 255, 0, 255);
      add_req(OP_PIXEL, 0, 255, 255, 255);
      add_req(OP_PIXEL, 255, 255, 255, 0);
      add_req(OP_PIXEL, 255, 255, 255, 255);
      add_req(OP_PIXEL, 7, 7, 7, 7);                // pixel past frame end, ignored
      repeat (4) add_req(OP_DRAIN, 0, 0, 0, 0);
   endfunction

   // one color component near the key, or anywhere
   function automatic int unsigned near_key(int unsigned k, int unsigned spread);
      int v;
      if ($urandom_range(0, 3) == 0) return $urandom_range(0, 255);
      v = int'(k) + int'($urandom_range(0, 2 * spread)) - int'(spread);
      return (v < 0) ? 0 : ((v > 255) ? 255 : v);
   endfunction

   // one well-formed frame with random content and some ignored noise
   task automatic run_frame(int unsigned w_val, int unsigned h_val);
      int unsigned w, h, spread;
      req_type     q;
      wait_idle();
      write_csr(REG_KEY_RED, $urandom_range(0, 255));
      write_csr(REG_KEY_GREEN, $urandom_range(0, 255));
      write_csr(REG_KEY_BLUE, $urandom_range(0, 255));
      case ($urandom_range(0, 5))
         0: write_csr(REG_TIGHT_LIMIT, 0);
         1: write_csr(REG_TIGHT_LIMIT, 195075);
         default: write_csr(REG_TIGHT_LIMIT, $urandom_range(0, 3000));
      endcase
      case ($urandom_range(0, 5))
         0: write_csr(REG_LOOSE_LIMIT, 0);
         1: write_csr(REG_LOOSE_LIMIT, 195075);
         default: write_csr(REG_LOOSE_LIMIT, $urandom_range(500, 40000));
      endcase
      write_csr(REG_IMAGE_WIDTH, w_val);
      write_csr(REG_IMAGE_HEIGHT, h_val);
      w = clamp_dim(w_val, MAX_W);
      h = clamp_dim(h_val, MAX_H);
      spread = $urandom_range(2, 60);
      for (int unsigned n = 0; n < w * h; n++) begin
         if ($urandom_range(0, 30) == 0) begin
            q = '0;
            q.opcode = OP_DRAIN;
            send_request(q);
         end
         q.opcode = OP_PIXEL;
         q.in_red = 8'(near_key(key_r, spread));
         q.in_green = 8'(near_key(key_g, spread));
         q.in_blue = 8'(near_key(key_b, spread));
         case ($urandom_range(0, 7))
            0: q.in_alpha = 8'd0;
            1, 2: q.in_alpha = 8'($urandom_range(0, 255));
            default: q.in_alpha = 8'd255;
         endcase
         send_request(q);
      end
      if ($urandom_range(0, 3) == 0) begin
         q.opcode = OP_PIXEL;
         send_request(q);
      end
      q.opcode = OP_DRAIN;
      while (pending != 0) begin
         q.in_red = 8'($urandom_range(0, 255));
         send_request(q);
      end
   endtask

   // ---------------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------------
   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      burst_left = 0;
      items_sent = 0;
      key_r = 0; key_g = 0; key_b = 0;
      tight_lim = TIGHT_RESET;
      loose_lim = LOOSE_RESET;
      width_reg = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      store_wp = 0;
      hist_wp = 0;
      reset_counters();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      build_directed();
      foreach (steps[i]) begin
         if (steps[i].is_csr) begin
            wait_idle();
            write_csr(steps[i].idx, steps[i].value);
         end else send_request(steps[i].q, steps[i].known, steps[i].typed);
      end

      // one wide frame and clamped sizes, then mostly small frames
      run_frame(200, 3);
      run_frame(0, 3);
      run_frame(5, 0);
      while (items_sent < 1700) begin
         if ($urandom_range(0, 9) == 0) run_frame($urandom_range(1, 40), $urandom_range(1, 4));
         else run_frame($urandom_range(1, 9), $urandom_range(1, 8));
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (mismatches == 0 && expected_pixels.size() == 0)
         $display("chroma_key_with_fringe_cleanup_core: match");
      else
         $display("chroma_key_with_fringe_cleanup_core: mismatch");
      $finish;
   end

   // hard stop well beyond the slowest correct run
   initial begin
      #50ms;
      $display("chroma_key_with_fringe_cleanup_core: mismatch");
      $finish;
   end

endmodule

/* sim.f */
sv/ckfc_pkg.sv
sv/ckfc_ram.sv
sv/ckfc_front.sv
sv/ckfc_back.sv
sv/chroma_key_with_fringe_cleanup_core.sv
sim/tb_chroma_key_with_fringe_cleanup_core.sv
